// File: hdl/ilc_pkg.sv
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types, codes and character helpers for the INI line classifier.
// ----------------------------------------------------------------------------
package ilc_pkg;

    typedef enum logic [2:0] {
        PH_LEAD     = 3'd0,
        PH_COMMENT  = 3'd1,
        PH_KEY      = 3'd2,
        PH_PRE_EQ   = 3'd3,
        PH_POST_EQ  = 3'd4,
        PH_VALUE    = 3'd5,
        PH_ERROR    = 3'd6
    } phase_t;

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_COMMENT = 2'd2;
    localparam logic [1:0] KIND_REPORT  = 2'd3;

    localparam logic [1:0] LINE_COMMENT = 2'd0;
    localparam logic [1:0] LINE_EMPTY   = 2'd1;
    localparam logic [1:0] LINE_KEY     = 2'd2;
    localparam logic [1:0] LINE_ERROR   = 2'd3;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] char_out;
        logic [1:0] line_kind;
        logic [1:0] quote_kind;
        logic       last_of_run;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_key_byte(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], ["0":"9"]}) ||
               (c == CH_UNDER) || (c == CH_DOT);
    endfunction

endpackage

// File: hdl/ilc_if.sv
// ----------------------------------------------------------------------------
// ilc_if
// Valid/ready channels: input bytes and result items.
// ----------------------------------------------------------------------------
interface ilc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ilc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] char_out;
    logic [1:0] line_kind;
    logic [1:0] quote_kind;
    logic       last_of_run;

    modport source (output valid, output item_kind, output char_out, output line_kind,
                    output quote_kind, output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input char_out, input line_kind,
                    input quote_kind, input last_of_run, output ready);
endinterface

// File: hdl/ilc_parser.sv
// ----------------------------------------------------------------------------
// ilc_parser
// Line state and per-byte classification; yields up to two results per byte.
// ----------------------------------------------------------------------------
module ilc_parser
    import ilc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    output logic [1:0] res_count,
    output result_t    res0,
    output result_t    res1
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] first_byte_reg, first_byte_next;
    logic [1:0] value_count_reg, value_count_next;
    logic       restart;
    logic [1:0] qk;

    function automatic result_t byte_res(input logic [1:0] kind, input logic [7:0] c,
                                         input logic last);
        result_t r;
        r.item_kind   = kind;
        r.char_out    = c;
        r.line_kind   = LINE_COMMENT;
        r.quote_kind  = QUOTE_NONE;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic result_t report_res(input logic [1:0] lk, input logic [1:0] q);
        result_t r;
        r.item_kind   = KIND_REPORT;
        r.char_out    = CH_NUL;
        r.line_kind   = lk;
        r.quote_kind  = q;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    // quote check at end of value: closing byte equals opening quote
    always_comb
    begin
        qk = QUOTE_NONE;
        if (value_count_reg == 2'd2 && held_byte_reg == first_byte_reg)
        begin
            if (first_byte_reg == CH_SQUOTE)
                qk = QUOTE_SINGLE;
            else if (first_byte_reg == CH_DQUOTE)
                qk = QUOTE_DOUBLE;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        held_byte_next   = held_byte_reg;
        held_valid_next  = held_valid_reg;
        first_byte_next  = first_byte_reg;
        value_count_next = value_count_reg;
        restart          = 1'b0;
        res_count        = 2'd0;
        res0             = '0;
        res1             = '0;

        case (phase_reg)
            PH_COMMENT:
            begin
                if (char_in == CH_NUL)
                begin
                    restart   = 1'b1;
                    res0      = report_res(LINE_COMMENT, QUOTE_NONE);
                    res_count = 2'd1;
                end
                else
                begin
                    res0      = byte_res(KIND_COMMENT, char_in, 1'b1);
                    res_count = 2'd1;
                end
            end
            PH_KEY:
            begin
                if (char_in == CH_NUL)
                begin
                    restart   = 1'b1;
                    res0      = report_res(LINE_ERROR, QUOTE_NONE);
                    res_count = 2'd1;
                end
                else if (is_key_byte(char_in))
                begin
                    res0      = byte_res(KIND_KEY, char_in, 1'b1);
                    res_count = 2'd1;
                end
                else if (is_blank(char_in))
                    phase_next = PH_PRE_EQ;
                else if (char_in == CH_EQ)
                    phase_next = PH_POST_EQ;
                else
                    phase_next = PH_ERROR;
            end
            PH_PRE_EQ:
            begin
                if (char_in == CH_NUL)
                begin
                    restart   = 1'b1;
                    res0      = report_res(LINE_ERROR, QUOTE_NONE);
                    res_count = 2'd1;
                end
                else if (char_in == CH_EQ)
                    phase_next = PH_POST_EQ;
                else if (!is_blank(char_in))
                    phase_next = PH_ERROR;
            end
            PH_POST_EQ:
            begin
                if (char_in == CH_NUL)
                begin
                    restart   = 1'b1;
                    res0      = report_res(LINE_KEY, QUOTE_NONE);
                    res_count = 2'd1;
                end
                else if (!is_blank(char_in))
                begin
                    held_byte_next   = char_in;
                    held_valid_next  = 1'b1;
                    first_byte_next  = char_in;
                    value_count_next = 2'd1;
                    phase_next       = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (char_in == CH_NUL)
                begin
                    restart = 1'b1;
                    if (qk != QUOTE_NONE)
                    begin
                        // closing quote is swallowed
                        res0      = report_res(LINE_KEY, qk);
                        res_count = 2'd1;
                    end
                    else if (held_valid_reg)
                    begin
                        res0      = byte_res(KIND_VALUE, held_byte_reg, 1'b0);
                        res1      = report_res(LINE_KEY, QUOTE_NONE);
                        res_count = 2'd2;
                    end
                    else
                    begin
                        res0      = report_res(LINE_KEY, QUOTE_NONE);
                        res_count = 2'd1;
                    end
                end
                else
                begin
                    if (held_valid_reg)
                    begin
                        res0      = byte_res(KIND_VALUE, held_byte_reg, 1'b1);
                        res_count = 2'd1;
                    end
                    held_byte_next  = char_in;
                    held_valid_next = 1'b1;
                    if (value_count_reg != 2'd2)
                        value_count_next = value_count_reg + 2'd1;
                end
            end
            PH_ERROR:
            begin
                if (char_in == CH_NUL)
                begin
                    restart   = 1'b1;
                    res0      = report_res(LINE_ERROR, QUOTE_NONE);
                    res_count = 2'd1;
                end
            end
            default:
            begin
                if (char_in == CH_NUL)
                begin
                    restart   = 1'b1;
                    res0      = report_res(LINE_EMPTY, QUOTE_NONE);
                    res_count = 2'd1;
                end
                else if (is_blank(char_in))
                    phase_next = PH_LEAD;
                else if (char_in == CH_SEMI || char_in == CH_HASH)
                begin
                    phase_next = PH_COMMENT;
                    res0       = byte_res(KIND_COMMENT, char_in, 1'b1);
                    res_count  = 2'd1;
                end
                else if (is_key_byte(char_in))
                begin
                    phase_next = PH_KEY;
                    res0       = byte_res(KIND_KEY, char_in, 1'b1);
                    res_count  = 2'd1;
                end
                else
                    phase_next = PH_ERROR;
            end
        endcase

        if (restart)
        begin
            phase_next       = PH_LEAD;
            held_byte_next   = CH_NUL;
            held_valid_next  = 1'b0;
            first_byte_next  = CH_NUL;
            value_count_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            held_byte_reg   <= CH_NUL;
            held_valid_reg  <= 1'b0;
            first_byte_reg  <= CH_NUL;
            value_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            held_byte_reg   <= held_byte_next;
            held_valid_reg  <= held_valid_next;
            first_byte_reg  <= first_byte_next;
            value_count_reg <= value_count_next;
        end
    end

endmodule

// File: hdl/ilc_result_fifo.sv
// ----------------------------------------------------------------------------
// ilc_result_fifo
// Small result queue: takes up to two results per cycle, sends one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module ilc_result_fifo
    import ilc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    ilc_out_if.source  result_out
);

    result_t              entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;
    logic [PTR_W-1:0]     wr_ptr_plus1;
    result_t              head;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = result_out.valid && result_out.ready;
    // room for the worst case of two results from one byte
    assign room         = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign result_out.valid       = (count_reg != '0);
    assign result_out.item_kind   = head.item_kind;
    assign result_out.char_out    = head.char_out;
    assign result_out.line_kind   = head.line_kind;
    assign result_out.quote_kind  = head.quote_kind;
    assign result_out.last_of_run = head.last_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/ini_line_classifier.sv
// ----------------------------------------------------------------------------
// ini_line_classifier
// Classifies one INI line per run of bytes ending in a zero byte.
// ----------------------------------------------------------------------------
//  channel     dir  payload                                             
//  line_in     in   char_in[7:0]                                        
//  result_out  out  item_kind, char_out, line_kind, quote_kind, last_of_run
//
//  A byte is classified in the cycle it is taken; its results are written
//  into a four-entry queue and leave one per cycle while the output is ready.
//  A new byte is taken every cycle while the queue has room for two results,
//  so a stalled output stops the input once the queue holds more than two.
//  Reset (rst_n low) returns to the start of a line and empties the queue.
// ----------------------------------------------------------------------------
module ini_line_classifier
    import ilc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ilc_in_if.sink     line_in,
    ilc_out_if.source  result_out
);

    logic       room;
    logic       accept;
    logic [1:0] res_count;
    logic [1:0] push_count;
    result_t    res0;
    result_t    res1;

    assign line_in.ready = room;
    assign accept        = line_in.valid && room;
    assign push_count    = accept ? res_count : 2'd0;

    ilc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (line_in.char_in),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    ilc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .result_out (result_out)
    );

endmodule

// File: dv/tb_ini_line_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ini_line_classifier
// Self-checking bench: feeds INI lines byte by byte with random gaps and
// output stalls, predicts every result item and compares them in order.
// ----------------------------------------------------------------------------
module tb_ini_line_classifier;
    import ilc_pkg::*;

    typedef struct {
        logic [7:0] ch;
        bit         drain;  // wait for all results before offering this byte
    } line_byte_t;

    logic clk;
    logic rst_n;

    ilc_in_if  line_if();
    ilc_out_if res_if();

    ini_line_classifier u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (line_if),
        .result_out (res_if)
    );

    line_byte_t line_q[$];
    result_t    expected_q[$];

    // predictor state
    phase_t     cur_phase;
    logic [7:0] held_ch;
    logic       held_ok;
    logic [7:0] first_val;
    logic [1:0] val_cnt;
    logic       saw_key;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  byte_taken;
    bit  drain_next;
    bit  long_hold_req;
    int  hold_left;
    int  bytes_in;
    int  queued_cnt;
    int  mismatch_cnt;
    int  cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_space_ch(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_name_ch(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic result_t make_item(input logic [1:0] kind, input logic [7:0] ch,
                                          input logic [1:0] lk, input logic [1:0] qk);
        result_t r;
        r.item_kind   = kind;
        r.char_out    = ch;
        r.line_kind   = lk;
        r.quote_kind  = qk;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic clear_line_state();
        cur_phase = PH_LEAD;
        held_ch   = 8'h00;
        held_ok   = 1'b0;
        first_val = 8'h00;
        val_cnt   = 2'd0;
        saw_key   = 1'b0;
    endtask

    // Works out the result items one accepted byte produces.
    task automatic classify_char(input logic [7:0] c);
        result_t    outs [2];
        int         n;
        bit         rep;
        logic [1:0] rep_line;
        logic [1:0] qk;
        n        = 0;
        rep      = 1'b0;
        rep_line = LINE_ERROR;
        qk       = QUOTE_NONE;
        case (cur_phase)
            PH_COMMENT:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_COMMENT;
                end
                else
                begin
                    outs[n++] = make_item(KIND_COMMENT, c, 2'd0, QUOTE_NONE);
                end
            end
            PH_KEY:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_ERROR;
                end
                else if (is_name_ch(c))
                    outs[n++] = make_item(KIND_KEY, c, 2'd0, QUOTE_NONE);
                else if (is_space_ch(c))
                    cur_phase = PH_PRE_EQ;
                else if (c == CH_EQ)
                    cur_phase = PH_POST_EQ;
                else
                    cur_phase = PH_ERROR;
            end
            PH_PRE_EQ:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_ERROR;
                end
                else if (c == CH_EQ)
                    cur_phase = PH_POST_EQ;
                else if (!is_space_ch(c))
                    cur_phase = PH_ERROR;
            end
            PH_POST_EQ:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_KEY;
                end
                else if (!is_space_ch(c))
                begin
                    held_ch   = c;
                    held_ok   = 1'b1;
                    first_val = c;
                    val_cnt   = 2'd1;
                    cur_phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_KEY;
                    if (val_cnt >= 2'd2 && held_ch == first_val)
                    begin
                        if (first_val == CH_SQUOTE)
                            qk = QUOTE_SINGLE;
                        else if (first_val == CH_DQUOTE)
                            qk = QUOTE_DOUBLE;
                    end
                    // closing quote is swallowed; otherwise flush the delayed byte
                    if (qk == QUOTE_NONE && held_ok)
                        outs[n++] = make_item(KIND_VALUE, held_ch, 2'd0, QUOTE_NONE);
                end
                else
                begin
                    if (held_ok)
                        outs[n++] = make_item(KIND_VALUE, held_ch, 2'd0, QUOTE_NONE);
                    held_ch = c;
                    held_ok = 1'b1;
                    if (val_cnt < 2'd2)
                        val_cnt = val_cnt + 2'd1;
                end
            end
            PH_ERROR:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_ERROR;
                end
            end
            default:
            begin
                if (c == CH_NUL)
                begin
                    rep = 1'b1;
                    rep_line = LINE_EMPTY;
                end
                else if (is_space_ch(c))
                begin
                end
                else if (c == CH_SEMI || c == CH_HASH)
                begin
                    cur_phase = PH_COMMENT;
                    outs[n++] = make_item(KIND_COMMENT, c, 2'd0, QUOTE_NONE);
                end
                else if (is_name_ch(c))
                begin
                    cur_phase = PH_KEY;
                    saw_key   = 1'b1;
                    outs[n++] = make_item(KIND_KEY, c, 2'd0, QUOTE_NONE);
                end
                else
                    cur_phase = PH_ERROR;
            end
        endcase
        if (rep)
        begin
            outs[n++] = make_item(KIND_REPORT, CH_NUL, rep_line, qk);
            clear_line_state();
        end
        if (n > 0)
            outs[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_q.push_back(outs[i]);
    endtask

    task automatic push_ch(input logic [7:0] c);
        line_byte_t b;
        b.ch  = c;
        b.drain = drain_next;
        drain_next = 1'b0;
        line_q.push_back(b);
        queued_cnt++;
    endtask

    function automatic logic [7:0] rand_blank();
        int idx;
        idx = $urandom_range(0, 5);
        return (idx == 5) ? CH_SPACE : 8'h09 + idx[7:0];
    endfunction

    function automatic logic [7:0] rand_name();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26)
            return 8'h61 + idx[7:0];
        else if (idx < 52)
            return 8'h41 + idx[7:0] - 8'd26;
        else if (idx < 62)
            return 8'h30 + idx[7:0] - 8'd52;
        else if (idx == 62)
            return CH_UNDER;
        return CH_DOT;
    endfunction

    function automatic logic [7:0] rand_text();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic add_random_line();
        int         pick;
        int         len;
        logic [7:0] q;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(0, 2);
        for (int i = 0; i < len; i++)
            push_ch(rand_blank());
        if (pick < 10)
        begin
            push_ch($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
                push_ch(rand_text());
        end
        else if (pick < 15)
        begin
            // blanks only: empty line
        end
        else if (pick < 80)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                push_ch(rand_name());
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                push_ch(rand_blank());
            push_ch(CH_EQ);
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                push_ch(rand_blank());
            case ($urandom_range(0, 3))
                0:
                begin
                    len = $urandom_range(0, 6);
                    for (int i = 0; i < len; i++)
                        push_ch(rand_text());
                end
                1, 2:
                begin
                    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                    push_ch(q);
                    len = $urandom_range(0, 5);
                    for (int i = 0; i < len; i++)
                        push_ch(rand_text());
                    // mostly a matching close, sometimes the other quote or none
                    case ($urandom_range(0, 5))
                        0: push_ch((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
                        1: ;
                        default: push_ch(q);
                    endcase
                end
                default:
                begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        push_ch(rand_name());
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        push_ch(rand_blank());
                end
            endcase
        end
        else if (pick < 90)
        begin
            // key without '=' or with a stray byte after it
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                push_ch(rand_name());
            if ($urandom_range(0, 1))
                push_ch(rand_blank());
            if ($urandom_range(0, 1))
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_ch(rand_text());
            end
        end
        else
        begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
                push_ch(rand_text());
        end
        push_ch(CH_NUL);
    endtask

    task automatic wait_drained();
        while (line_q.size() != 0 || line_if.valid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_bytes,
                             input bit with_hold);
        int start_cnt;
        int start_in;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start_cnt = queued_cnt;
        start_in  = bytes_in;
        while (queued_cnt - start_cnt < n_bytes / 2)
            add_random_line();
        drain_next = 1'b1;
        while (queued_cnt - start_cnt < n_bytes)
            add_random_line();
        if (with_hold)
        begin
            while (bytes_in - start_in < 40)
                @(negedge clk);
            long_hold_req = 1'b1;
        end
        wait_drained();
    endtask

    // input driver
    always @(negedge clk)
    begin
        line_byte_t cur;
        if (rst_n)
        begin
            if (line_if.valid && !byte_taken)
            begin
                // transaction still pending
            end
            else
            begin
                byte_taken = 1'b0;
                if (line_q.size() == 0 ||
                    (line_q[0].drain && expected_q.size() != 0) ||
                    $urandom_range(0, 99) < send_idle_pct)
                begin
                    line_if.valid <= 1'b0;
                end
                else
                begin
                    cur = line_q.pop_front();
                    line_if.valid   <= 1'b1;
                    line_if.char_in <= cur.ch;
                end
            end
        end
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left = 300;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (line_if.valid && line_if.ready)
            begin
                classify_char(line_if.char_in);
                byte_taken = 1'b1;
                bytes_in++;
            end
            if (res_if.valid && res_if.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: kind=%0d ch=%02h line=%0d quote=%0d last=%0d",
                                 res_if.item_kind, res_if.char_out, res_if.line_kind,
                                 res_if.quote_kind, res_if.last_of_run);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res_if.item_kind !== want.item_kind ||
                        res_if.char_out !== want.char_out ||
                        res_if.line_kind !== want.line_kind ||
                        res_if.quote_kind !== want.quote_kind ||
                        res_if.last_of_run !== want.last_of_run)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: exp kind=%0d ch=%02h line=%0d quote=%0d ",
                                      "last=%0d, got kind=%0d ch=%02h line=%0d quote=%0d ",
                                      "last=%0d"},
                                     want.item_kind, want.char_out, want.line_kind,
                                     want.quote_kind, want.last_of_run,
                                     res_if.item_kind, res_if.char_out, res_if.line_kind,
                                     res_if.quote_kind, res_if.last_of_run);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 200000)
        begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] directed [$];
        directed = '{
            CH_NUL,                                          // empty line
            8'h09, CH_SEMI, 8'h80, CH_NUL,                   // comment, high byte
            CH_HASH, 8'hFF, CH_NUL,                          // hash comment
            8'h3F, 8'h61, CH_NUL,                            // bad leading byte
            8'h5A, CH_NUL,                                   // missing equals
            CH_UNDER, 8'h21, CH_NUL,                         // bad byte after key
            CH_DOT, CH_SPACE, CH_EQ, CH_NUL,                 // empty value
            8'h6B, CH_EQ, CH_SQUOTE, 8'h78, CH_SQUOTE, CH_NUL,
            8'h61, CH_EQ, CH_DQUOTE, CH_DQUOTE, CH_NUL
        };
        rst_n           = 1'b0;
        line_if.valid   = 1'b0;
        line_if.char_in = 8'h00;
        res_if.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        byte_taken      = 1'b0;
        drain_next      = 1'b0;
        long_hold_req   = 1'b0;
        hold_left       = 0;
        bytes_in        = 0;
        queued_cnt      = 0;
        mismatch_cnt    = 0;
        cycle_cnt       = 0;
        clear_line_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 74;
        foreach (directed[i])
            push_ch(directed[i]);
        wait_drained();

        run_phase(35, 74, 220, 1'b0);
        run_phase(74, 35, 220, 1'b0);
        run_phase(0, 0, 230, 1'b1);

        repeat (20) @(negedge clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
